@@ src/fpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared types and constants for the frame pacing and skip controller.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    localparam int FPER_W   = 13;                 // frame_period register width
    localparam int SPEED_W  = 3;                  // speed_mode register width
    localparam int CFG_W    = FPER_W;             // widest register
    localparam int SCALED_W = FPER_W + 1;         // up to period * 2
    localparam int INTEG_W  = 32;

    localparam logic [FPER_W-1:0] PERIOD_RESET = 13'd1667;
    localparam logic [FPER_W-1:0] PERIOD_MAX   = 13'd6553;
    localparam logic [8:0]        ELAPSED_MAX  = 9'd327;
    localparam logic [1:0]        WARMUP_SYNCS = 2'd3;
    localparam logic [6:0]        MS_TO_10US   = 7'd100;

    // configuration register indexes
    localparam logic CFG_FRAME_PERIOD = 1'b0;
    localparam logic CFG_SPEED_MODE   = 1'b1;

    // speed modes
    localparam logic [SPEED_W-1:0] SPEED_1X    = 3'd0;
    localparam logic [SPEED_W-1:0] SPEED_0P5X  = 3'd1;
    localparam logic [SPEED_W-1:0] SPEED_0P75X = 3'd2;
    localparam logic [SPEED_W-1:0] SPEED_1P25X = 3'd3;
    localparam logic [SPEED_W-1:0] SPEED_1P5X  = 3'd4;
    localparam logic [SPEED_W-1:0] SPEED_2X    = 3'd5;
    localparam logic [SPEED_W-1:0] SPEED_3X    = 3'd6;

    // input ops
    localparam logic OP_SYNC    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic       op;
        logic [8:0] elapsed_ms;
    } t_in;

    typedef struct packed {
        logic        draw_en;
        logic [1:0]  skip_level;
        logic        pause_request;
        logic [15:0] skipped_total;
    } t_out;

endpackage

@@ src/fpsc_period.sv @@
// ----------------------------------------------------------------------------
// fpsc_period
// Configuration registers and the registered, speed-scaled frame period.
// ----------------------------------------------------------------------------
module fpsc_period
    import fpsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic [SCALED_W-1:0] o_period
);

    logic [FPER_W-1:0]   r_frame_period;
    logic [SPEED_W-1:0]  r_speed_mode;
    logic [SCALED_W-1:0] r_period;
    logic [SCALED_W-1:0] n_period;

    logic [FPER_W-1:0] w_p;
    logic [15:0]       w_x5;      // p * 5
    logic [14:0]       w_x4;      // p * 4
    logic [14:0]       w_x2;      // p * 2
    logic [31:0]       w_div5;
    logic [31:0]       w_div3;
    logic [14:0]       w_div3_arg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= PERIOD_RESET;
            r_speed_mode   <= SPEED_1X;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_PERIOD: r_frame_period <= i_cfg_data[FPER_W-1:0];
                CFG_SPEED_MODE:   r_speed_mode   <= i_cfg_data[SPEED_W-1:0];
                default:          r_speed_mode   <= r_speed_mode;
            endcase
        end
        r_period <= n_period;
    end

    always_comb begin
        w_p  = (r_frame_period > PERIOD_MAX) ? PERIOD_MAX : r_frame_period;
        w_x5 = {3'b000, w_p} + {1'b0, w_p, 2'b00};
        w_x4 = {w_p, 2'b00};
        w_x2 = {1'b0, w_p, 1'b0};
        // reciprocal multiplies, exact for 16-bit dividends
        w_div5 = ({17'd0, w_x4} * 32'd52429) >> 18;
        w_div3_arg = (r_speed_mode == SPEED_1P5X) ? w_x2 : {2'b00, w_p};
        w_div3 = ({17'd0, w_div3_arg} * 32'd43691) >> 17;

        unique case (r_speed_mode)
            SPEED_0P5X:  n_period = w_x2[SCALED_W-1:0];
            SPEED_0P75X: n_period = w_x5[15:2];
            SPEED_1P25X: n_period = w_div5[SCALED_W-1:0];
            SPEED_1P5X:  n_period = w_div3[SCALED_W-1:0];
            SPEED_2X:    n_period = {2'b00, w_p[FPER_W-1:1]};
            SPEED_3X:    n_period = w_div3[SCALED_W-1:0];
            default:     n_period = {1'b0, w_p};
        endcase
    end

    assign o_period = r_period;

endmodule

@@ src/fpsc_core.sv @@
// ----------------------------------------------------------------------------
// fpsc_core
// Pacing state update and result register for one frame-sync word a cycle while i_adv is high.
// ----------------------------------------------------------------------------
module fpsc_core
    import fpsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_in_valid,
    input  t_in                 i_in,
    input  logic [SCALED_W-1:0] i_period,
    output logic                o_valid,
    output t_out                o_out
);

    logic signed [INTEG_W-1:0] r_integ;
    logic [1:0]                r_skip;
    logic [1:0]                r_startup;
    logic [15:0]               r_skip_cnt;
    logic                      r_valid;
    t_out                      r_out;

    logic signed [INTEG_W-1:0] n_integ;
    logic [1:0]                n_skip;
    logic [1:0]                n_startup;
    logic [15:0]               n_skip_cnt;
    t_out                      n_out;

    logic [8:0]             w_ms;
    logic [14:0]            w_e100;
    logic signed [16:0]     w_diff;
    logic signed [INTEG_W:0] w_sum;
    logic signed [INTEG_W-1:0] w_sat;
    logic signed [INTEG_W:0] w_sat_x;
    logic signed [INTEG_W:0] w_p1;
    logic signed [INTEG_W:0] w_p2;
    logic                   w_pause;
    logic [1:0]             w_lvl;

    always_comb begin
        w_ms   = (i_in.elapsed_ms > ELAPSED_MAX) ? ELAPSED_MAX : i_in.elapsed_ms;
        w_e100 = 15'({6'd0, w_ms} * {8'd0, MS_TO_10US});
        w_diff = $signed({2'b00, w_e100}) - $signed({3'b000, i_period});
        w_sum  = $signed({r_integ[INTEG_W-1], r_integ})
               + $signed({{(INTEG_W-16){w_diff[16]}}, w_diff});
        // clamp to the signed 32-bit range
        if (w_sum[INTEG_W] != w_sum[INTEG_W-1])
            w_sat = w_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                   : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            w_sat = w_sum[INTEG_W-1:0];
        w_sat_x = $signed({w_sat[INTEG_W-1], w_sat});
        w_p1    = $signed({{(INTEG_W+1-SCALED_W){1'b0}}, i_period});
        w_p2    = $signed({{(INTEG_W-SCALED_W){1'b0}}, i_period, 1'b0});

        w_pause = 1'b0;
        priority if (w_sat_x > w_p2) begin
            w_lvl = 2'd2;
        end else if (w_sat_x > w_p1) begin
            w_lvl = 2'd1;
        end else begin
            w_lvl   = 2'd0;
            w_pause = (w_sat_x < -w_p1);
        end

        n_integ    = r_integ;
        n_skip     = r_skip;
        n_startup  = r_startup;
        n_skip_cnt = r_skip_cnt;
        n_out      = r_out;

        unique case (i_in.op)
            OP_RESTART: begin
                n_integ    = '0;
                n_skip     = '0;
                n_startup  = '0;
                n_skip_cnt = '0;
                n_out      = '0;
            end
            default: begin
                n_out.draw_en = (r_skip < 2'd2);
                if (r_startup < WARMUP_SYNCS) begin
                    n_startup           = r_startup + 2'd1;
                    n_skip              = '0;
                    n_out.skip_level    = '0;
                    n_out.pause_request = 1'b0;
                    n_out.skipped_total = r_skip_cnt;
                end else begin
                    n_integ             = w_sat;
                    n_skip              = w_lvl;
                    n_skip_cnt          = r_skip_cnt + {14'd0, w_lvl};
                    n_out.skip_level    = w_lvl;
                    n_out.pause_request = w_pause;
                    n_out.skipped_total = n_skip_cnt;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_skip     <= '0;
            r_startup  <= '0;
            r_skip_cnt <= '0;
            r_valid    <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_in_valid;
            if (i_in_valid) begin
                r_integ    <= n_integ;
                r_skip     <= n_skip;
                r_startup  <= n_startup;
                r_skip_cnt <= n_skip_cnt;
            end
        end
        if (i_adv && i_in_valid)
            r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

@@ src/frame_pacing_skip_controller.sv @@
// ----------------------------------------------------------------------------
// frame_pacing_skip_controller
// Frame pacing: draw flag, skip level and pause request per frame sync.
// ----------------------------------------------------------------------------
// Takes one word per clock while not stalled and returns one result word per
// input word, held first in the input register and then in the output
// register fed by the state update. The two register stages let a new
// word enter while a finished result waits on a stalled output. The scaled
// frame period is registered from the configuration registers, so a new
// configuration applies to words accepted from the cycle after the write.
// ----------------------------------------------------------------------------
module frame_pacing_skip_controller
    import fpsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out
);

    logic                r_in_valid;
    t_in                 r_in;
    logic                w_adv;
    logic [SCALED_W-1:0] w_period;

    // pipeline moves when the output register is free or being taken
    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall)
            r_in <= i_in;
    end

    fpsc_period u_period (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_period    (w_period)
    );

    fpsc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_in_valid (r_in_valid),
        .i_in       (r_in),
        .i_period   (w_period),
        .o_valid    (o_out_valid),
        .o_out      (o_out)
    );

    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.skip_level != 2'd3))
        else $error("skip level out of range");

    a_skip_pause_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.pause_request && (o_out.skip_level != 2'd0)))
        else $error("pause and skip both set");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule

@@ verif/frame_pacing_skip_controller_tb.sv @@
// ----------------------------------------------------------------------------
// frame_pacing_skip_controller_tb
// Self-checking bench for the frame pacing and skip controller.
// ----------------------------------------------------------------------------
// A queue-fed driver sends sync and restart words in random bursts while the
// output side stalls on a shifting pattern. Each accepted word runs through a
// behavioral pacing model that keeps its own integrator, skip and startup
// state, and every result word is compared field by field with the oldest
// prediction. The run walks through every speed mode and the period extremes,
// then sends back-to-back words with no stalls for steady skips and pauses.
// ----------------------------------------------------------------------------
module frame_pacing_skip_controller_tb;
    import fpsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STUCK_LIMIT = 1000;
    localparam int     PHASES      = 14;
    localparam int     PHASE_WORDS = 100;
    localparam int     MS_ALL_ONES = (1 << 9) - 1;
    localparam int     PERIOD_ONES = (1 << FPER_W) - 1;
    localparam longint ACC_MAX     = 64'sd2147483647;
    localparam longint ACC_MIN     = -64'sd2147483648;
    localparam int     FAST_WORDS  = 100;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_FRAME_PERIOD;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in              in_word   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out             out_word;

    frame_pacing_skip_controller i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // register copies and pacing state
    logic [FPER_W-1:0]  cur_period = PERIOD_RESET;
    logic [SPEED_W-1:0] cur_speed  = SPEED_1X;
    int                 integ_acc  = 0;
    logic [1:0]         held_skip  = '0;
    logic [1:0]         warmup     = '0;
    logic [15:0]        skipped    = '0;

    t_in  frames_q[$];
    t_out pace_results_q[$];
    int   n_queued    = 0;
    int   n_taken     = 0;
    int   n_mismatch  = 0;
    logic frame_taken = 1'b0;
    logic fast_run    = 1'b0;

    function automatic int pace_period();
        int p;
        p = int'((cur_period > PERIOD_MAX) ? PERIOD_MAX : cur_period);
        case (cur_speed)
            SPEED_1X:    return p;
            SPEED_0P5X:  return p * 2;
            SPEED_0P75X: return (p * 5) / 4;
            SPEED_1P25X: return (p * 4) / 5;
            SPEED_1P5X:  return (p * 2) / 3;
            SPEED_2X:    return p / 2;
            SPEED_3X:    return p / 3;
            default:     return p;
        endcase
    endfunction

    function automatic t_out pace_frame(t_in w);
        t_out   r;
        int     ms;
        int     per;
        longint sum;
        r = '0;
        if (w.op == OP_RESTART) begin
            integ_acc = 0;
            held_skip = '0;
            warmup    = '0;
            skipped   = '0;
            return r;
        end
        r.draw_en = (held_skip < 2'd2);
        held_skip = '0;
        if (warmup < WARMUP_SYNCS) begin
            warmup = warmup + 2'd1;
            r.draw_en = 1'b1;
            r.skipped_total = skipped;
            return r;
        end
        ms  = (w.elapsed_ms > ELAPSED_MAX) ? int'(ELAPSED_MAX) : int'(w.elapsed_ms);
        per = pace_period();
        sum = longint'(integ_acc) + longint'(ms * int'(MS_TO_10US) - per);
        if (sum > ACC_MAX) sum = ACC_MAX;
        else if (sum < ACC_MIN) sum = ACC_MIN;
        integ_acc = int'(sum);
        if (integ_acc > 2 * per) held_skip = 2'd2;
        else if (integ_acc > per) held_skip = 2'd1;
        else if (integ_acc < -per) r.pause_request = 1'b1;
        skipped = skipped + 16'(held_skip);
        r.skip_level    = held_skip;
        r.skipped_total = skipped;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            n_mismatch++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic queue_frame(logic op, int ms);
        t_in w;
        w.op = op;
        w.elapsed_ms = 9'(ms);
        frames_q.push_back(w);
        n_queued++;
    endtask

    task automatic wait_idle();
        while (n_queued != n_taken || pace_results_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        wait_idle();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        if (idx == CFG_FRAME_PERIOD) cur_period = FPER_W'(val);
        else cur_speed = SPEED_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        // scaled period is registered in the cycle after the write
        repeat (2) @(negedge clk);
    endtask

    // sender: bursts and gaps, payload held while stalled
    int gap_left   = 0;
    int burst_left = 1;

    always @(negedge clk) begin : drive_frames
        t_in  nxt_word;
        logic nxt_valid;
        nxt_word  = in_word;
        nxt_valid = in_valid;
        if (!in_valid || frame_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0 && !fast_run) begin
                gap_left = gap_left - 1;
            end else if (frames_q.size() > 0) begin
                nxt_word  = frames_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left = burst_left - 1;
                end
            end
        end
        in_valid <= nxt_valid;
        in_word  <= nxt_word;
    end

    // receiver: stall pattern swapped each time stall_tick wraps to zero, bit 0 always open
    logic [7:0] stall_pat  = '0;
    logic [5:0] stall_tick = '0;

    always @(negedge clk) begin : drive_stall
        if (fast_run) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_tick == 6'd0) begin
                stall_pat = ($urandom_range(0, 3) == 0) ? 8'h00 : (8'($urandom) & 8'hFE);
            end
            stall_tick = stall_tick + 6'd1;
            out_stall <= stall_pat[stall_tick[2:0]];
        end
    end

    always @(posedge clk) begin : watch_ports
        t_out want;
        if (!rst_n) begin
            frame_taken <= 1'b0;
        end else begin
            frame_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                pace_results_q.push_back(pace_frame(in_word));
                n_taken++;
            end
            if (out_valid && !out_stall) begin
                if (pace_results_q.size() == 0) begin
                    n_mismatch++;
                    $error("result word with nothing pending");
                end else begin
                    want = pace_results_q.pop_front();
                    check_field("draw_en", want.draw_en, out_word.draw_en);
                    check_field("skip_level", want.skip_level, out_word.skip_level);
                    check_field("pause_request", want.pause_request, out_word.pause_request);
                    check_field("skipped_total", want.skipped_total, out_word.skipped_total);
                end
            end
        end
    end

    int stuck_cycles = 0;

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("frame_pacing_skip_controller verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int per;
        int mode;
        int tgt;
        int ms;
        int roll;
        int hold_at;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: startup, skip 2 then no draw, restart, skip 1
        queue_frame(OP_SYNC, 0);
        queue_frame(OP_SYNC, MS_ALL_ONES);
        queue_frame(OP_SYNC, ELAPSED_MAX);
        queue_frame(OP_SYNC, 17);
        queue_frame(OP_SYNC, MS_ALL_ONES);
        queue_frame(OP_SYNC, 17);
        queue_frame(OP_SYNC, 0);
        queue_frame(OP_SYNC, 0);
        queue_frame(OP_SYNC, ELAPSED_MAX + 1);
        wait_idle();
        repeat (4) queue_frame(OP_SYNC, 0);
        queue_frame(OP_RESTART, MS_ALL_ONES);
        repeat (3) queue_frame(OP_SYNC, 0);
        queue_frame(OP_SYNC, 34);
        queue_frame(OP_SYNC, 50);
        queue_frame(OP_SYNC, 1);
        queue_frame(OP_RESTART, 0);
        queue_frame(OP_SYNC, 256);
        queue_frame(OP_SYNC, 170);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       per = 1;
                1:       per = PERIOD_MAX;
                2:       per = PERIOD_ONES;
                3:       per = 0;
                4:       per = PERIOD_MAX + 1;
                5:       per = PERIOD_RESET;
                default: per = $urandom_range(0, 1) ? $urandom_range(1, PERIOD_MAX)
                                                    : $urandom_range(0, PERIOD_ONES);
            endcase
            mode = (ph < 8) ? ph : $urandom_range(0, (1 << SPEED_W) - 1);
            write_reg(CFG_FRAME_PERIOD, per);
            write_reg(CFG_SPEED_MODE, mode);
            tgt = pace_period() / int'(MS_TO_10US);
            hold_at = (ph == 0) ? 55 : (($urandom_range(0, 2) == 0) ? $urandom_range(20, 90) : -1);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k == hold_at) wait_idle();
                roll = $urandom_range(0, 99);
                if (roll < 3 || (k == 0 && $urandom_range(0, 1) == 1)) begin
                    queue_frame(OP_RESTART, $urandom_range(0, MS_ALL_ONES));
                end else if (roll < 73) begin
                    // hover around the period so the integrator crosses thresholds
                    ms = tgt + $urandom_range(0, 8) - 4;
                    if (ms < 0) ms = 0;
                    if (ms > MS_ALL_ONES) ms = MS_ALL_ONES;
                    queue_frame(OP_SYNC, ms);
                end else if (roll < 93) begin
                    queue_frame(OP_SYNC, $urandom_range(0, MS_ALL_ONES));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       ms = 0;
                        1:       ms = ELAPSED_MAX;
                        2:       ms = ELAPSED_MAX + 1;
                        default: ms = MS_ALL_ONES;
                    endcase
                    queue_frame(OP_SYNC, ms);
                end
            end
        end

        // back-to-back words at full rate: steady skips, then steady pauses
        fast_run = 1'b1;
        write_reg(CFG_FRAME_PERIOD, 0);
        write_reg(CFG_SPEED_MODE, SPEED_1X);
        queue_frame(OP_RESTART, 0);
        repeat (FAST_WORDS) queue_frame(OP_SYNC, ELAPSED_MAX);
        write_reg(CFG_FRAME_PERIOD, PERIOD_MAX);
        write_reg(CFG_SPEED_MODE, SPEED_0P5X);
        queue_frame(OP_RESTART, 0);
        repeat (FAST_WORDS / 4) queue_frame(OP_SYNC, 0);
        wait_idle();
        fast_run = 1'b0;

        repeat (8) @(negedge clk);
        if (n_mismatch == 0 && pace_results_q.size() == 0) begin
            $display("frame_pacing_skip_controller verification clean");
        end else begin
            $display("frame_pacing_skip_controller verification failed");
        end
        $finish;
    end

endmodule
